>>> src/rsoz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsoz_pkg
// Shared types and constants for the run/sleep/ozone tick scheduler.
// ----------------------------------------------------------------------------
package rsoz_pkg;

    localparam int CFG_IDX_W = 4;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_USAGE_PERIOD   = 4'd0;
    localparam cfg_idx_t REG_OZONE_INTERVAL = 4'd1;
    localparam cfg_idx_t REG_OZONE_ON       = 4'd2;
    localparam cfg_idx_t REG_OZONE_CYCLE    = 4'd3;
    localparam cfg_idx_t REG_TICKS_PER_MIN  = 4'd4;
    localparam cfg_idx_t REG_MIN_PER_HOUR   = 4'd5;
    localparam cfg_idx_t REG_RUN_HOURS      = 4'd6;
    localparam cfg_idx_t REG_SLEEP_MINUTES  = 4'd7;

    localparam logic [15:0] RST_USAGE_PERIOD   = 16'd35550;
    localparam logic [15:0] RST_OZONE_INTERVAL = 16'd35500;
    localparam logic [15:0] RST_OZONE_ON       = 16'd200;
    localparam logic [15:0] RST_OZONE_CYCLE    = 16'd1800;
    localparam logic [15:0] RST_TICKS_PER_MIN  = 16'd1190;
    localparam logic [7:0]  RST_MIN_PER_HOUR   = 8'd59;
    localparam logic [7:0]  RST_RUN_HOURS      = 8'd8;
    localparam logic [7:0]  RST_SLEEP_MINUTES  = 8'd30;

    typedef struct packed {
        logic [15:0] usage_period_ticks;
        logic [15:0] ozone_interval_ticks;
        logic [15:0] ozone_on_ticks;
        logic [15:0] ozone_cycle_ticks;
        logic [15:0] ticks_per_minute;
        logic [7:0]  minutes_per_hour;
        logic [7:0]  run_hours_limit;
        logic [7:0]  sleep_minutes_limit;
    } rsoz_cfg_t;

    typedef struct packed {
        logic [15:0] usage_tick_count;
        logic [15:0] usage_hour_count;
        logic [15:0] reaction_hour_count;
        logic [15:0] ozone_tick_count;
        logic [15:0] second_count;
        logic [15:0] minute_count;
        logic [15:0] hour_count;
        logic        sleep_mode;
        logic        ozone_cycling;
        logic        ozone_level;
    } rsoz_state_t;

    typedef struct packed {
        logic        ozone_on;
        logic        motor_write;
        logic [7:0]  motor_speed;
        logic        display_off;
        logic        save_request;
        logic [15:0] usage_hours;
        logic [15:0] reaction_hours;
        logic        sleeping;
    } rsoz_result_t;

endpackage

>>> src/rsoz_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsoz_step
// Next-state and result logic for one tick.
// ----------------------------------------------------------------------------
module rsoz_step
(
    input  rsoz_pkg::rsoz_cfg_t    cfg,
    input  rsoz_pkg::rsoz_state_t  state,
    input  logic                   filter_absent,
    input  logic [7:0]             speed_level,
    output rsoz_pkg::rsoz_state_t  state_next,
    output rsoz_pkg::rsoz_result_t result
);
    import rsoz_pkg::*;

    logic [15:0] ot;
    logic [15:0] sc;
    logic [15:0] ut;
    logic [15:0] uh;
    logic [15:0] rh;
    logic [15:0] mc;
    logic [15:0] hc;
    logic        sm;
    logic        oc;
    logic        ol;
    logic        save;
    logic        mwrite;
    logic        doff;
    logic [7:0]  mspeed;

    always_comb
    begin
        ot     = state.ozone_tick_count + 16'd1;
        sc     = state.second_count + 16'd1;
        ut     = state.usage_tick_count + 16'd1;
        uh     = state.usage_hour_count;
        rh     = state.reaction_hour_count;
        mc     = state.minute_count;
        hc     = state.hour_count;
        sm     = state.sleep_mode;
        oc     = state.ozone_cycling;
        ol     = state.ozone_level;
        save   = 1'b0;
        mwrite = 1'b0;
        doff   = 1'b0;
        mspeed = 8'd0;

        if (ut == cfg.usage_period_ticks)
        begin
            ut   = 16'd0;
            uh   = uh + 16'd1;
            rh   = rh + 16'd1;
            save = 1'b1;
        end

        if (ot == cfg.ozone_interval_ticks && !filter_absent && !sm)
        begin
            ot = 16'd0;
            oc = 1'b1;
            ol = 1'b1;
        end
        if (oc)
        begin
            if (ot == cfg.ozone_on_ticks)
                ol = 1'b0;
            if (ot == cfg.ozone_cycle_ticks)
            begin
                ot = 16'd0;
                ol = 1'b1;
            end
        end

        if (sc == cfg.ticks_per_minute && !filter_absent)
        begin
            sc = 16'd0;
            mc = mc + 16'd1;
            if (mc == {8'd0, cfg.minutes_per_hour} && !sm)
            begin
                mc = 16'd0;
                hc = hc + 16'd1;
                if (hc == {8'd0, cfg.run_hours_limit})
                begin
                    sc     = 16'd0;
                    hc     = 16'd0;
                    sm     = 1'b1;
                    doff   = 1'b1;
                    mwrite = 1'b1;
                    mspeed = 8'd0;
                    oc     = 1'b0;
                    ol     = 1'b0;
                end
            end
            if (mc == {8'd0, cfg.sleep_minutes_limit} && sm)
            begin
                ot     = 16'd0;
                sc     = 16'd0;
                mc     = 16'd0;
                hc     = 16'd0;
                sm     = 1'b0;
                mwrite = 1'b1;
                mspeed = speed_level;
            end
        end

        state_next.usage_tick_count    = ut;
        state_next.usage_hour_count    = uh;
        state_next.reaction_hour_count = rh;
        state_next.ozone_tick_count    = ot;
        state_next.second_count        = sc;
        state_next.minute_count        = mc;
        state_next.hour_count          = hc;
        state_next.sleep_mode          = sm;
        state_next.ozone_cycling       = oc;
        state_next.ozone_level         = ol;

        result.ozone_on       = ol;
        result.motor_write    = mwrite;
        result.motor_speed    = mspeed;
        result.display_off    = doff;
        result.save_request   = save;
        result.usage_hours    = uh;
        result.reaction_hours = rh;
        result.sleeping       = sm;
    end

endmodule

>>> src/run_sleep_ozone_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_sleep_ozone_scheduler_core
// Tick scheduler: usage hours with save request, periodic ozone cycle,
// run/sleep clock driving motor and display.
// ----------------------------------------------------------------------------
// Output: the result is registered and valid in the cycle after the tick request is accepted.
// Throughput: one tick request per cycle; the result register decouples
// the two sides, so input stalls only while a result waits under stall.
// Reset: all counters and flags clear, config registers take their defaults,
// output register empty.
// ----------------------------------------------------------------------------
module run_sleep_ozone_scheduler_core
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  rsoz_pkg::cfg_idx_t      cfg_index,
    input  logic [15:0]             cfg_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    filter_absent,
    input  logic [7:0]              speed_level,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    ozone_on,
    output logic                    motor_write,
    output logic [7:0]              motor_speed,
    output logic                    display_off,
    output logic                    save_request,
    output logic [15:0]             usage_hours,
    output logic [15:0]             reaction_hours,
    output logic                    sleeping
);
    import rsoz_pkg::*;

    rsoz_cfg_t    cfg_reg;
    rsoz_state_t  state_reg;
    rsoz_state_t  state_next;
    rsoz_result_t result_next;
    rsoz_result_t result_reg;
    logic         out_valid_reg;
    logic         accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.usage_period_ticks   <= RST_USAGE_PERIOD;
            cfg_reg.ozone_interval_ticks <= RST_OZONE_INTERVAL;
            cfg_reg.ozone_on_ticks       <= RST_OZONE_ON;
            cfg_reg.ozone_cycle_ticks    <= RST_OZONE_CYCLE;
            cfg_reg.ticks_per_minute     <= RST_TICKS_PER_MIN;
            cfg_reg.minutes_per_hour     <= RST_MIN_PER_HOUR;
            cfg_reg.run_hours_limit      <= RST_RUN_HOURS;
            cfg_reg.sleep_minutes_limit  <= RST_SLEEP_MINUTES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_USAGE_PERIOD:   cfg_reg.usage_period_ticks   <= cfg_data;
                REG_OZONE_INTERVAL: cfg_reg.ozone_interval_ticks <= cfg_data;
                REG_OZONE_ON:       cfg_reg.ozone_on_ticks       <= cfg_data;
                REG_OZONE_CYCLE:    cfg_reg.ozone_cycle_ticks    <= cfg_data;
                REG_TICKS_PER_MIN:  cfg_reg.ticks_per_minute     <= cfg_data;
                REG_MIN_PER_HOUR:   cfg_reg.minutes_per_hour     <= cfg_data[7:0];
                REG_RUN_HOURS:      cfg_reg.run_hours_limit      <= cfg_data[7:0];
                REG_SLEEP_MINUTES:  cfg_reg.sleep_minutes_limit  <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    rsoz_step u_step
    (
        .cfg           (cfg_reg),
        .state         (state_reg),
        .filter_absent (filter_absent),
        .speed_level   (speed_level),
        .state_next    (state_next),
        .result        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign ozone_on       = result_reg.ozone_on;
    assign motor_write    = result_reg.motor_write;
    assign motor_speed    = result_reg.motor_speed;
    assign display_off    = result_reg.display_off;
    assign save_request   = result_reg.save_request;
    assign usage_hours    = result_reg.usage_hours;
    assign reaction_hours = result_reg.reaction_hours;
    assign sleeping       = result_reg.sleeping;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted tick produced no result");

    a_idle_motor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.motor_write |-> result_reg.motor_speed == 8'd0)
        else $error("motor speed set without motor write");

    a_blank_has_motor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.display_off |-> result_reg.motor_write)
        else $error("display blanked without motor command");

    a_sleep_no_ozone: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.sleep_mode |-> !state_reg.ozone_cycling && !state_reg.ozone_level)
        else $error("ozone active while sleeping");

    a_save_bumps_hours: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result_next.save_request
        |=> state_reg.usage_hour_count == $past(state_reg.usage_hour_count) + 16'd1)
        else $error("save request without usage hour increment");

endmodule
